[src/rau_pkg.sv]
// Package for the rational arithmetic unit: opcodes, widths and word types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
	localparam int OpW = 32;
	localparam int DblW = 64;
	localparam int DefWidth = 32;

	localparam logic [2:0] FUNC_ADD = 3'd0;
	localparam logic [2:0] FUNC_SUB = 3'd1;
	localparam logic [2:0] FUNC_MUL = 3'd2;
	localparam logic [2:0] FUNC_DIV = 3'd3;
	localparam logic [2:0] FUNC_NEG = 3'd4;
	localparam logic [2:0] FUNC_CMP = 3'd5;

	typedef logic [DblW-1:0] dword_t;
	typedef logic [OpW-1:0] word_t;
endpackage
`default_nettype wire

[src/rau_divider.sv]
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 64-bit divisor.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rau_divider (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire rau_pkg::dword_t dividend,
	input  wire rau_pkg::dword_t divisor,
	output logic               done,
	output rau_pkg::dword_t    quotient
);
	import rau_pkg::*;

	dword_t quo_q;
	dword_t dvs_q;
	logic [DblW:0] rem_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [DblW:0] shifted;
	logic [DblW:0] diff;

	assign shifted = {rem_q[DblW-1:0], quo_q[DblW-1]};
	assign diff = shifted - {1'b0, dvs_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(DblW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[DblW]) begin
				rem_q <= diff;
				quo_q <= {quo_q[DblW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DblW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

[src/rational_arithmetic_unit.sv]
// Top level of the rational arithmetic unit: sequencer, shared multiplier, binary gcd
// and the divider for reduction. Depends on rau_pkg and rau_divider.
//
//   channel | signals                                   | direction
//   in      | in_valid, in_ready, func, a/b num and den | into the block
//   out     | out_valid, out_ready, res_*, flags        | out of the block
//
// An arithmetic item passes through the multiply states, the combine state, the binary
// gcd states (one shift or subtract per step) and two divisions. Negate goes from the
// first multiply state straight to the gcd, skipping the others and the combine state.
// Compare goes from the last multiply state to the output state, divide by zero and
// unused opcodes from the first. in_ready is high whenever the sequencer is idle;
// a finished result waits in the sequencer while the output register still holds an
// untaken one. Reset clears the sequencer and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit #(
	parameter int WIDTH = rau_pkg::DefWidth
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         func,
	input  wire logic signed [31:0] a_num,
	input  wire logic [31:0]        a_den,
	input  wire logic signed [31:0] b_num,
	input  wire logic [31:0]        b_den,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      res_num,
	output logic [31:0]         res_den,
	output logic                    is_equal,
	output logic                    is_less,
	output logic                    overflow,
	output logic                    div_by_zero
);
	import rau_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL1 = 4'd1;
	localparam logic [3:0] ST_MUL2 = 4'd2;
	localparam logic [3:0] ST_MUL3 = 4'd3;
	localparam logic [3:0] ST_COMB = 4'd4;
	localparam logic [3:0] ST_GINIT = 4'd5;
	localparam logic [3:0] ST_GTWO = 4'd6;
	localparam logic [3:0] ST_GA = 4'd7;
	localparam logic [3:0] ST_GLOOP = 4'd8;
	localparam logic [3:0] ST_DIV1 = 4'd9;
	localparam logic [3:0] ST_DIV2 = 4'd10;
	localparam logic [3:0] ST_FIN = 4'd11;
	localparam logic [3:0] ST_OUT = 4'd12;

	localparam dword_t WMask = dword_t'((65'd1 << WIDTH) - 65'd1);
	localparam dword_t Half = dword_t'(64'd1 << (WIDTH - 1));

	logic [3:0] state_q;
	logic [2:0] func_q;
	logic an_neg_q, bn_neg_q;
	word_t an_mag_q, ad_q, bn_mag_q, bd_q;
	dword_t p1_q, p2_q, p3_q;
	logic n_neg_q;
	dword_t n_mag_q, den_q;
	dword_t ga_q, gb_q;
	logic [6:0] k_q;
	dword_t g_q;
	word_t wnum_q, wden_q;
	logic weq_q, wlt_q, wovf_q, wdz_q;

	word_t mul_x, mul_y;
	dword_t prod;
	assign prod = dword_t'(mul_x) * dword_t'(mul_y);

	logic div_start;
	dword_t div_dvd;
	logic div_done;
	dword_t div_quo;
	logic out_load;

	rau_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(g_q), .done(div_done), .quotient(div_quo)
	);

	always_comb begin
		unique case (state_q)
			ST_MUL1: begin
				mul_x = an_mag_q;
				mul_y = (func_q == FUNC_MUL) ? bn_mag_q : bd_q;
			end
			ST_MUL2: begin
				mul_x = (func_q == FUNC_DIV) ? ad_q : bn_mag_q;
				mul_y = (func_q == FUNC_DIV) ? bn_mag_q : ad_q;
			end
			ST_MUL3: begin
				mul_x = ad_q;
				mul_y = bd_q;
			end
			default: begin
				mul_x = ad_q;
				mul_y = bd_q;
			end
		endcase
	end

	logic r_neg;
	logic l_neg;
	logic cmp_eq, cmp_lt;
	always_comb begin
		l_neg = an_neg_q && (p1_q != '0);
		r_neg = (bn_neg_q != (func_q == FUNC_SUB)) && (p2_q != '0);
		cmp_eq = (l_neg == r_neg) && (p1_q == p2_q);
		if (l_neg != r_neg)
			cmp_lt = l_neg;
		else if (l_neg)
			cmp_lt = p1_q > p2_q;
		else
			cmp_lt = p1_q < p2_q;
	end

	dword_t gdiff;
	assign gdiff = (ga_q > gb_q) ? ga_q - gb_q : gb_q - ga_q;

	logic fin_ovf;
	dword_t fin_bits;
	always_comb begin
		fin_ovf = (den_q > WMask) ||
			(n_neg_q ? (n_mag_q > Half) : (n_mag_q > Half - 64'd1));
		fin_bits = (n_neg_q ? (64'd0 - n_mag_q) : n_mag_q) & WMask;
		if ((fin_bits & Half) != '0)
			fin_bits = fin_bits | ~WMask;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_OUT) && (!out_valid || out_ready);
	assign div_start = (state_q == ST_DIV1 || state_q == ST_DIV2) && (k_q == 7'd127);
	assign div_dvd = (state_q == ST_DIV1) ? n_mag_q : den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_load)
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid && in_ready) state_q <= ST_MUL1;
				ST_MUL1: begin
					priority if (func_q == FUNC_NEG) state_q <= ST_GINIT;
					else if (func_q > FUNC_CMP) state_q <= ST_OUT;
					else if (func_q == FUNC_DIV && bn_mag_q == '0) state_q <= ST_OUT;
					else state_q <= ST_MUL2;
				end
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= (func_q == FUNC_CMP) ? ST_OUT : ST_COMB;
				ST_COMB: state_q <= ST_GINIT;
				ST_GINIT: state_q <= ST_GTWO;
				ST_GTWO: if (ga_q == '0 || gb_q == '0 || ga_q[0] || gb_q[0])
					state_q <= ST_GA;
				ST_GA: if (ga_q == '0 || gb_q == '0 || ga_q[0]) state_q <= ST_GLOOP;
				ST_GLOOP: if (gb_q == '0 || ga_q == '0) state_q <= ST_DIV1;
				ST_DIV1: if (div_done) state_q <= ST_DIV2;
				ST_DIV2: if (div_done) state_q <= ST_FIN;
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				func_q <= func;
				an_neg_q <= a_num[31];
				an_mag_q <= a_num[31] ? word_t'(32'd0 - a_num) : word_t'(a_num);
				bn_neg_q <= b_num[31];
				bn_mag_q <= b_num[31] ? word_t'(32'd0 - b_num) : word_t'(b_num);
				ad_q <= a_den;
				bd_q <= b_den;
				k_q <= '0;
			end
			ST_MUL1: begin
				p1_q <= prod;
				wnum_q <= '0;
				wden_q <= 32'd1;
				weq_q <= 1'b0;
				wlt_q <= 1'b0;
				wovf_q <= 1'b0;
				wdz_q <= (func_q == FUNC_DIV) && (bn_mag_q == '0);
				n_neg_q <= !an_neg_q && (an_mag_q != '0);
				n_mag_q <= dword_t'(an_mag_q);
				den_q <= dword_t'(ad_q);
			end
			ST_MUL2: p2_q <= prod;
			ST_MUL3: begin
				p3_q <= prod;
				if (func_q == FUNC_CMP) begin
					weq_q <= cmp_eq;
					wlt_q <= cmp_lt;
				end
			end
			ST_COMB: begin
				den_q <= (func_q == FUNC_DIV) ? p2_q : p3_q;
				priority if (func_q == FUNC_MUL || func_q == FUNC_DIV) begin
					n_neg_q <= (an_neg_q != bn_neg_q) && (p1_q != '0);
					n_mag_q <= p1_q;
				end else if (l_neg == r_neg) begin
					n_neg_q <= l_neg && (p1_q + p2_q != '0);
					n_mag_q <= p1_q + p2_q;
				end else if (p1_q >= p2_q) begin
					n_neg_q <= l_neg && (p1_q != p2_q);
					n_mag_q <= p1_q - p2_q;
				end else begin
					n_neg_q <= r_neg;
					n_mag_q <= p2_q - p1_q;
				end
			end
			ST_GINIT: begin
				ga_q <= n_mag_q;
				gb_q <= den_q;
				k_q <= '0;
			end
			ST_GTWO: if (!(ga_q == '0 || gb_q == '0 || ga_q[0] || gb_q[0])) begin
				ga_q <= ga_q >> 1;
				gb_q <= gb_q >> 1;
				k_q <= k_q + 7'd1;
			end
			ST_GA: if (!(ga_q == '0 || gb_q == '0 || ga_q[0])) ga_q <= ga_q >> 1;
			ST_GLOOP: begin
				if (ga_q == '0 || gb_q == '0) begin
					if ((ga_q | gb_q) == '0) g_q <= 64'd1;
					else g_q <= (ga_q | gb_q) << k_q[5:0];
					k_q <= 7'd127;
				end else if (!gb_q[0]) gb_q <= gb_q >> 1;
				else begin
					ga_q <= (ga_q > gb_q) ? gb_q : ga_q;
					gb_q <= gdiff;
				end
			end
			ST_DIV1: begin
				if (div_done) n_mag_q <= div_quo;
				k_q <= div_done ? 7'd127 : 7'd0;
			end
			ST_DIV2: begin
				if (div_done) den_q <= div_quo;
				k_q <= 7'd0;
			end
			ST_FIN: begin
				wnum_q <= fin_bits[31:0];
				wden_q <= den_q[31:0] & WMask[31:0];
				wovf_q <= fin_ovf;
			end
			default: ;
		endcase
		if (out_load) begin
			res_num <= wnum_q;
			res_den <= wden_q;
			is_equal <= weq_q;
			is_less <= wlt_q;
			overflow <= wovf_q;
			div_by_zero <= wdz_q;
		end
	end
endmodule
`default_nettype wire
